FILE: hw/rtl/sprite_line_collision_engine_top_macros.svh
// Assertion macros for the sprite line collision engine checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef SPRITE_LINE_COLLISION_ENGINE_TOP_MACROS_SVH
`define SPRITE_LINE_COLLISION_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SLCE_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SLCE_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/slce_pkg.sv
// Shared types, constants and helpers of the sprite line collision engine.
// No dependencies.
`default_nettype none
package slce_pkg;

  localparam int LINE_WIDTH  = 320;
  localparam int NUM_SPRITES = 16;

  localparam int ADDR_W    = $clog2(LINE_WIDTH);
  localparam int SPR_W     = $clog2(NUM_SPRITES);
  localparam int OWNER_W   = 5;
  localparam int COLOR_W   = 24;
  localparam int ENTRY_W   = COLOR_W + OWNER_W;
  localparam int PAT_LEN   = 16;
  localparam int PIX_W     = $clog2(PAT_LEN) + 1;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [2:0] OP_FRAME = 3'd0;
  localparam logic [2:0] OP_ROW   = 3'd1;
  localparam logic [2:0] OP_DRAW  = 3'd2;
  localparam logic [2:0] OP_RDPIX = 3'd3;
  localparam logic [2:0] OP_RDCOL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GM_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GM_HIGH  = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DRAW,
    ST_DRAWEND,
    ST_RDPIX,
    ST_FINISH
  } state_t;

  function automatic logic [7:0] group_of(input logic [3:0] s, input logic [127:0] masks);
    return masks[{s, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/slce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sprite_line_collision_engine_top.sv
// Sprite line collision engine top level; uses slce_pkg and slce_ram.
// Path from input beat to result beat: a draw passes ST_DRAW and ST_DRAWEND, a row start
// ST_FILL, an in-range read pixel ST_RDPIX, and every opcode then ST_FINISH. One item at a time;
// a draw takes one pixel per cycle through the line RAM's single read port.
// Reset (rst, synchronous) starts a clearing pass over every line RAM address;
// no input beat is taken until it ends, configuration writes are.
`default_nettype none
module sprite_line_collision_engine_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_tdata, lowest bit up: opcode[3], sprite_id[4], x_pos[12], pattern[16],
  // color_red[8], color_green[8], color_blue[8], read_index[11], zero pad[2]
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [slce_pkg::IN_W-1:0]       s_tdata,
  // m_tdata, lowest bit up: pixel_red[8], pixel_green[8], pixel_blue[8],
  // collision_bits[8]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [slce_pkg::OUT_W-1:0]      m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [slce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [slce_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import slce_pkg::*;

  // Input beat fields
  logic [2:0]  in_op;
  logic [3:0]  in_sid;
  logic [11:0] in_x;
  logic [15:0] in_pat;
  logic [23:0] in_color;
  logic [10:0] in_idx;

  assign in_op    = s_tdata[2:0];
  assign in_sid   = s_tdata[6:3];
  assign in_x     = s_tdata[18:7];
  assign in_pat   = s_tdata[34:19];
  assign in_color = {s_tdata[42:35], s_tdata[50:43], s_tdata[58:51]};
  assign in_idx   = s_tdata[69:59];

  // Configuration registers
  logic [7:0]   bg_red;
  logic [7:0]   bg_green;
  logic [7:0]   bg_blue;
  logic [63:0]  gm_low;
  logic [63:0]  gm_high;
  logic [127:0] masks;

  assign masks     = {gm_high, gm_low};
  assign cfg_ready = 1'b1;

  // Sequencer and item registers
  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  cnt;
  logic [PIX_W-1:0]   pix;
  logic [3:0]         sid;
  logic [11:0]        x_pos;
  logic [15:0]        pat;
  logic [23:0]        color;
  logic [OUT_W-1:0]   res;
  logic               st_valid;
  logic [ADDR_W-1:0]  st_addr;
  logic [7:0]         acc;
  logic [7:0]         flags [NUM_SPRITES];

  logic               in_fire;
  logic               out_free;
  logic               fill_last;

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign fill_last = (cnt == ADDR_W'(LINE_WIDTH - 1));

  // Line RAM: colour in the upper bits, owner (0 none, s+1 sprite s) below
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  slce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pixel position of the pattern bit under issue; 13 bits hold the sign
  logic [12:0]        pos;
  logic               pos_ok;
  logic               pix_done;
  logic               issue;

  assign pix_done = pix[PIX_W-1];
  assign pos      = {x_pos[11], x_pos} + 13'(pix[PIX_W-2:0]);
  assign pos_ok   = !pos[12] && (pos < 13'(LINE_WIDTH));
  assign issue    = !pix_done && pat[4'(PAT_LEN - 1) - pix[PIX_W-2:0]] && pos_ok;

  // Owner of the pixel read in the previous cycle
  logic [OWNER_W-1:0] own;
  logic [3:0]         other;
  logic               other_ok;

  assign own      = ram_rdata[OWNER_W-1:0];
  assign other    = 4'(own - OWNER_W'(1));
  assign other_ok = ({1'b0, other} < 5'(NUM_SPRITES));

  // Collision flag file: one address per cycle, shared by read and write
  logic [SPR_W-1:0]   flg_addr;
  logic [7:0]         flg_rdata;
  logic               flg_we;
  logic [7:0]         flg_wdata;

  assign flg_rdata = flags[flg_addr];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_ROW:   state_next = ST_FILL;
            OP_DRAW: begin
              if ({1'b0, in_sid} < 5'(NUM_SPRITES)) state_next = ST_DRAW;
              else state_next = ST_FINISH;
            end
            OP_RDPIX: begin
              if ({1'b0, in_idx} < 12'(LINE_WIDTH)) state_next = ST_RDPIX;
              else state_next = ST_FINISH;
            end
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_last) state_next = ST_FINISH;
      end
      ST_DRAW: begin
        if (pix_done) state_next = ST_DRAWEND;
      end
      ST_DRAWEND: state_next = ST_FINISH;
      ST_RDPIX:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory and flag file control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = {bg_red, bg_green, bg_blue, OWNER_W'(0)};
    ram_raddr = pos[ADDR_W-1:0];
    flg_addr  = other[SPR_W-1:0];
    flg_we    = 1'b0;
    flg_wdata = flg_rdata | group_of(sid, masks);
    case (state)
      ST_CLEAR, ST_FILL: begin
        // sweep: background colour, no owner
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_raddr = in_idx[ADDR_W-1:0];
        flg_addr  = in_idx[SPR_W-1:0];
      end
      ST_DRAW: begin
        if (st_valid) begin
          if (own == OWNER_W'(0)) begin
            ram_we    = 1'b1;
            ram_waddr = st_addr;
            ram_wdata = {color, OWNER_W'({1'b0, sid} + 5'd1)};
          end else if (other_ok) begin
            flg_we = 1'b1;
          end
        end
      end
      ST_DRAWEND: begin
        // fold the flags gathered for the drawing sprite
        flg_addr  = sid[SPR_W-1:0];
        flg_we    = 1'b1;
        flg_wdata = flg_rdata | acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      st_valid <= 1'b0;
      m_tvalid <= 1'b0;
      bg_red   <= 8'd8;
      bg_green <= 8'd0;
      bg_blue  <= 8'd8;
      gm_low   <= '0;
      gm_high  <= '0;
      for (int k = 0; k < NUM_SPRITES; k++) flags[k] <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BG_RED:   bg_red   <= cfg_data[7:0];
          CFG_BG_GREEN: bg_green <= cfg_data[7:0];
          CFG_BG_BLUE:  bg_blue  <= cfg_data[7:0];
          CFG_GM_LOW:   gm_low   <= cfg_data;
          CFG_GM_HIGH:  gm_high  <= cfg_data;
          default: begin
          end
        endcase
      end

      // advance the sweep address
      if (state == ST_CLEAR || state == ST_FILL) begin
        cnt <= fill_last ? '0 : cnt + ADDR_W'(1);
      end

      if (state == ST_IDLE && in_fire) begin
        sid   <= in_sid;
        x_pos <= in_x;
        pat   <= in_pat;
        color <= in_color;
        pix   <= '0;
        acc   <= '0;
        cnt   <= '0;
        if (in_op == OP_FRAME) begin
          for (int k = 0; k < NUM_SPRITES; k++) flags[k] <= '0;
        end
        if (in_op == OP_RDCOL && {1'b0, in_idx} < 12'(NUM_SPRITES)) begin
          res <= {flg_rdata, 24'd0};
        end else begin
          res <= '0;
        end
      end

      // draw: issue one pixel read and settle the previous one each cycle
      if (state == ST_DRAW) begin
        st_valid <= issue;
        st_addr  <= pos[ADDR_W-1:0];
        if (!pix_done) pix <= pix + PIX_W'(1);
        if (st_valid && own != OWNER_W'(0)) begin
          acc <= acc | group_of(other, masks);
        end
      end

      if (flg_we) flags[flg_addr] <= flg_wdata;

      if (state == ST_RDPIX) begin
        res <= {8'd0, ram_rdata[12:5], ram_rdata[20:13], ram_rdata[28:21]};
      end

      // load the next result beat when the register is free, else drop a taken one
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/slce_checker.sv
// Port-level checker for the sprite line collision engine, bound to the top.
// Depends on sprite_line_collision_engine_top_macros.svh.
`default_nettype none
`include "sprite_line_collision_engine_top_macros.svh"
module slce_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  `SLCE_AST_NXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "ready after input beat")
  `SLCE_AST_NXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")
  `SLCE_AST_NOW(a_result_frees_input, $rose(m_tvalid), s_tready, "result while busy")
  `SLCE_AST_NXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind sprite_line_collision_engine_top slce_checker u_slce_checker (.*);
`default_nettype wire

FILE: sim/tb_sprite_line_collision_engine_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sprite_line_collision_engine_top: sends command beats, keeps a
// shadow of line colours, pixel owners and collision flags, and checks every result beat.
// Depends on slce_pkg and the engine RTL only.
module tb_sprite_line_collision_engine_top;
  import slce_pkg::*;

  // Opcodes the engine does not decode; they must return zeros and change nothing.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int MAX_REPORTS   = 10;
  localparam int FILL_LATENCY  = LINE_WIDTH + 2;
  localparam int PHASE_BEATS   = 488;
  localparam int RUN_LIMIT_NS  = 8_000_000;

  // Command beat, lowest bit up, matching the s_tdata layout.
  typedef struct packed {
    logic [1:0]         pad;
    logic [10:0]        read_index;
    logic [7:0]         color_blue;
    logic [7:0]         color_green;
    logic [7:0]         color_red;
    logic [15:0]        pattern;
    logic signed [11:0] x_pos;
    logic [3:0]         sprite_id;
    logic [2:0]         opcode;
  } sprite_cmd_t;

  // Result beat, lowest bit up, matching the m_tdata layout.
  typedef struct packed {
    logic [7:0] collision_bits;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
  } line_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // Shadow of the engine: background, group masks, line and flag stores.
  logic [7:0]  bg_red_q     = 8'd8;
  logic [7:0]  bg_green_q   = 8'd0;
  logic [7:0]  bg_blue_q    = 8'd8;
  logic [63:0] masks_low_q  = '0;
  logic [63:0] masks_high_q = '0;
  logic [23:0] shadow_color [LINE_WIDTH];
  logic [4:0]  shadow_owner [LINE_WIDTH];
  logic [7:0]  shadow_flags [NUM_SPRITES];

  line_result_t pending_results[$];
  line_result_t beat_want;
  line_result_t beat_got;
  int           mismatch_count = 0;
  int           beats_sent     = 0;
  int           idle_pct       = 0;
  int           stall_pct      = 0;

  sprite_line_collision_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: stall at random per cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beat_got = m_tdata;
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result beat %h at %0t", beat_got, $time);
        mismatch_count++;
      end else begin
        beat_want = pending_results.pop_front();
        if (beat_got.pixel_red !== beat_want.pixel_red ||
            beat_got.pixel_green !== beat_want.pixel_green ||
            beat_got.pixel_blue !== beat_want.pixel_blue ||
            beat_got.collision_bits !== beat_want.collision_bits) begin
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: expected rgb %h %h %h flags %h, got rgb %h %h %h flags %h",
                     $time, beat_want.pixel_red, beat_want.pixel_green, beat_want.pixel_blue,
                     beat_want.collision_bits, beat_got.pixel_red, beat_got.pixel_green,
                     beat_got.pixel_blue, beat_got.collision_bits);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [7:0] group_mask(input logic [3:0] sprite);
    if (sprite[3])
      return masks_high_q[8 * sprite[2:0] +: 8];
    return masks_low_q[8 * sprite[2:0] +: 8];
  endfunction

  // Apply one command to the shadow and return the result it must produce.
  function automatic line_result_t composite_step(input sprite_cmd_t c);
    line_result_t r;
    int           pos;
    logic [3:0]   other;
    r = '0;
    case (c.opcode)
      OP_FRAME: begin
        for (int s = 0; s < NUM_SPRITES; s++) shadow_flags[s] = '0;
      end
      OP_ROW: begin
        for (int p = 0; p < LINE_WIDTH; p++) begin
          shadow_owner[p] = '0;
          shadow_color[p] = {bg_red_q, bg_green_q, bg_blue_q};
        end
      end
      OP_DRAW: begin
        // Bit 15 is the leftmost pixel; drop pixels that fall off the line.
        for (int k = 0; k < PAT_LEN; k++) begin
          pos = $signed(c.x_pos) + k;
          if (c.pattern[PAT_LEN-1-k] && pos >= 0 && pos < LINE_WIDTH) begin
            if (shadow_owner[pos] != '0) begin
              other = 4'(shadow_owner[pos] - 5'd1);
              shadow_flags[other]       |= group_mask(c.sprite_id);
              shadow_flags[c.sprite_id] |= group_mask(other);
            end else begin
              shadow_color[pos] = {c.color_red, c.color_green, c.color_blue};
              shadow_owner[pos] = {1'b0, c.sprite_id} + 5'd1;
            end
          end
        end
      end
      OP_RDPIX: begin
        if (c.read_index < LINE_WIDTH)
          {r.pixel_red, r.pixel_green, r.pixel_blue} = shadow_color[c.read_index];
      end
      OP_RDCOL: begin
        if (c.read_index < NUM_SPRITES)
          r.collision_bits = shadow_flags[c.read_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one command beat, idling first at random; valid stays high afterwards.
  task automatic send_cmd(input sprite_cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(composite_step(c));
    beats_sent++;
  endtask

  // Drop valid and hold until every expected result beat has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BG_RED:   bg_red_q     = val[7:0];
      CFG_BG_GREEN: bg_green_q   = val[7:0];
      CFG_BG_BLUE:  bg_blue_q    = val[7:0];
      CFG_GM_LOW:   masks_low_q  = val;
      CFG_GM_HIGH:  masks_high_q = val;
      default: ;
    endcase
  endtask

  // Write all five registers back to back; only call while the engine is idle.
  task automatic set_palette(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [63:0] lo,
                             input logic [63:0] hi);
    write_reg(CFG_BG_RED, {56'd0, red});
    write_reg(CFG_BG_GREEN, {56'd0, green});
    write_reg(CFG_BG_BLUE, {56'd0, blue});
    write_reg(CFG_GM_LOW, lo);
    write_reg(CFG_GM_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic sprite_cmd_t cmd(input logic [2:0] op, input logic [3:0] sid,
                                      input int x, input logic [15:0] pat,
                                      input logic [23:0] rgb, input int idx);
    sprite_cmd_t c;
    c = '0;
    c.opcode     = op;
    c.sprite_id  = sid;
    c.x_pos      = 12'(x);
    c.pattern    = pat;
    {c.color_red, c.color_green, c.color_blue} = rgb;
    c.read_index = 11'(idx);
    return c;
  endfunction

  // Every field random, any opcode including the spare ones.
  function automatic sprite_cmd_t noise_cmd();
    sprite_cmd_t c;
    c = '0;
    c.opcode      = 3'($urandom);
    c.sprite_id   = 4'($urandom);
    c.x_pos       = 12'($urandom);
    c.pattern     = 16'($urandom);
    c.color_red   = 8'($urandom);
    c.color_green = 8'($urandom);
    c.color_blue  = 8'($urandom);
    c.read_index  = 11'($urandom);
    return c;
  endfunction

  // One scanline: optional frame start, mostly a row start, then draws clustered around a
  // base position so sprites overlap, mixed with pixel and flag reads.
  task automatic run_scanline();
    sprite_cmd_t c;
    int          base;
    int          n_ops;
    base = $urandom_range(0, LINE_WIDTH - 32);
    if ($urandom_range(0, 3) == 0) begin
      c = noise_cmd();
      c.opcode = OP_FRAME;
      send_cmd(c);
    end
    // Now and then skip the row start and draw over the previous line.
    if ($urandom_range(0, 7) != 0) begin
      c = noise_cmd();
      c.opcode = OP_ROW;
      send_cmd(c);
    end
    n_ops = $urandom_range(6, 20);
    repeat (n_ops) begin
      c = noise_cmd();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          c.opcode = OP_DRAW;
          c.x_pos  = 12'(base + int'($urandom_range(0, 32)) - 16);
          if ($urandom_range(0, 7) == 0) c.pattern = 16'hFFFF;
        end
        6, 7: begin
          c.opcode     = OP_RDPIX;
          c.read_index = 11'(base + int'($urandom_range(0, 31)));
        end
        default: begin
          c.opcode     = OP_RDCOL;
          c.read_index = 11'($urandom_range(0, NUM_SPRITES - 1));
        end
      endcase
      send_cmd(c);
    end
  endtask

  // Reset values: background 8, 0, 8 and zero group masks, so overlaps flag nothing.
  task automatic test_reset_values();
    send_cmd(cmd(OP_ROW, 0, 0, 16'h0000, 24'h000000, 0));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, 5));
    send_cmd(cmd(OP_DRAW, 0, 0, 16'hFFFF, 24'h123456, 0));
    send_cmd(cmd(OP_DRAW, 1, 4, 16'hFFFF, 24'hABCDEF, 0));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 1));
  endtask

  // Field extremes, clipping at both ends, self overlap, reads out of range, spare opcodes.
  task automatic test_edge_cases();
    send_cmd(cmd(OP_FRAME, 0, 0, 16'h0000, 24'h000000, 0));
    send_cmd(cmd(OP_ROW, 0, 0, 16'h0000, 24'h000000, 0));
    send_cmd(cmd(OP_DRAW, 0, -2048, 16'hFFFF, 24'hFFFFFF, 0));
    send_cmd(cmd(OP_DRAW, 15, 2047, 16'hFFFF, 24'hFFFFFF, 2047));
    send_cmd(cmd(OP_DRAW, 1, -8, 16'hFFFF, 24'h112233, 0));
    send_cmd(cmd(OP_DRAW, 2, LINE_WIDTH - 8, 16'hFFFF, 24'h445566, 0));
    send_cmd(cmd(OP_DRAW, 3, 0, 16'h8000, 24'h778899, 0));
    send_cmd(cmd(OP_DRAW, 4, 100, 16'h0001, 24'hAABBCC, 0));
    send_cmd(cmd(OP_DRAW, 4, 108, 16'hFF00, 24'hDDEEFF, 0));
    send_cmd(cmd(OP_DRAW, 5, 200, 16'h0000, 24'h010203, 0));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, 0));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, LINE_WIDTH - 1));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, 115));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, LINE_WIDTH));
    send_cmd(cmd(OP_RDPIX, 0, 0, 16'h0000, 24'h000000, 2047));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 1));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 3));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 4));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, NUM_SPRITES));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 2047));
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_cmd(cmd(3'(op), 4'hF, -1, 16'hFFFF, 24'hFFFFFF, 2047));
    send_cmd(cmd(OP_FRAME, 0, 0, 16'h0000, 24'h000000, 0));
    send_cmd(cmd(OP_RDCOL, 0, 0, 16'h0000, 24'h000000, 3));
  endtask

  // Mostly well-formed scanlines, with bursts of random beats in between.
  task automatic test_random_traffic(input int n_beats, input int send_idle,
                                     input int sink_stall);
    int stop_at;
    idle_pct  = send_idle;
    stall_pct = sink_stall;
    stop_at   = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) send_cmd(noise_cmd());
      else
        run_scanline();
      // Pause the sender now and then until the engine has fully drained.
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    for (int p = 0; p < LINE_WIDTH; p++) begin
      shadow_owner[p] = '0;
      shadow_color[p] = '0;
    end
    for (int s = 0; s < NUM_SPRITES; s++) shadow_flags[s] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    wait_drained();
    set_palette(8'hFF, 8'h00, 8'hFF, 64'h8040_2010_0804_0201, 64'h0102_0408_1020_4080);
    test_edge_cases();
    wait_drained();

    set_palette(8'h00, 8'h00, 8'h00, '1, '1);
    test_random_traffic(PHASE_BEATS, 0, 0);
    set_palette(8'hFF, 8'hFF, 8'hFF, '0, '0);
    test_random_traffic(PHASE_BEATS, 50, 0);
    set_palette(8'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom},
                {$urandom, $urandom});
    test_random_traffic(PHASE_BEATS, 0, 50);
    set_palette(8'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom},
                {$urandom, $urandom});
    test_random_traffic(PHASE_BEATS, 19, 19);

    // Let any stray late beat show up before the verdict.
    repeat (FILL_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sprite_line_collision_engine_top.f
+incdir+hw/rtl
hw/rtl/slce_pkg.sv
hw/rtl/slce_ram.sv
hw/rtl/sprite_line_collision_engine_top.sv
hw/rtl/slce_checker.sv
sim/tb_sprite_line_collision_engine_top.sv
